>>> hw/rtl/alpe_pkg.sv
// alpe_pkg: shared constants, register codes, state and command types
// for the addressable LED pulse encoder. No dependencies.
package alpe_pkg;

  localparam int PIXELS     = 64;
  localparam int FRAME_BITS = PIXELS * 24;
  localparam int PIX_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int BP_W       = $clog2(FRAME_BITS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] HIGH_ONE_RESET  = 24'd200000;
  localparam logic [23:0] HIGH_ZERO_RESET = 24'd100000;
  localparam logic [23:0] PERIOD_RESET    = 24'd300000;
  localparam logic [23:0] REFRESH_RESET   = 24'd4000000;
  localparam logic [23:0] ENABLE_MASK     = 24'h000001;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_HIGH_ONE  = 3'd1,
    CFG_HIGH_ZERO = 3'd2,
    CFG_PERIOD    = 3'd3,
    CFG_REFRESH   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPDATE = 4'b0010,
    ST_READ   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic update;
    logic read;
    logic load_out;
  } dp_cmd_t;

endpackage

>>> hw/rtl/addressable_led_pulse_encoder.sv
// addressable_led_pulse_encoder: top level of the one-wire LED chain pulse encoder.
// Depends on alpe_pkg, alpe_ctrl, alpe_dp (and alpe_ram through alpe_dp).
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  in       | in_valid / in_stall      | operation, pixel_index, red, green, blue
//  out      | out_valid / out_stall    | line_level, bit_number, in_gap, frame_done
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// each item passes the steps accept, counter and bank update, frame bank read,
// result load in turn; a new item is taken only once the last one is loaded into the result register
// the result register holds while out_stall is high; the next item is taken
// meanwhile, and its result waits in the last step until the register frees
// synchronous active high reset; pixel and frame stores read as zero after reset
// cfg_ready is always high
module addressable_led_pulse_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [5:0]                      pixel_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            line_level,
  output logic [10:0]                     bit_number,
  output logic                            in_gap,
  output logic                            frame_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alpe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import alpe_pkg::*;

  dp_cmd_t cmd;

  alpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  alpe_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (operation),
    .pixel_index(pixel_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .line_level (line_level),
    .bit_number (bit_number),
    .in_gap     (in_gap),
    .frame_done (frame_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

>>> hw/rtl/alpe_ram.sv
// alpe_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module alpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/alpe_ctrl.sv
// alpe_ctrl: item sequencing state machine and output handshake.
// Depends on alpe_pkg.
module alpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output alpe_pkg::dp_cmd_t cmd
);
  import alpe_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/alpe_dp.sv
// alpe_dp: configuration registers, pixel and frame banks, bit sequencer
// counters and result register. Depends on alpe_pkg and alpe_ram.
module alpe_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  alpe_pkg::dp_cmd_t                   cmd,
  input  logic                                operation,
  input  logic [5:0]                          pixel_index,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  output logic                                line_level,
  output logic [10:0]                         bit_number,
  output logic                                in_gap,
  output logic                                frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [alpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alpe_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import alpe_pkg::*;

  // configuration
  logic        enable;
  logic [23:0] high_one;
  logic [23:0] high_zero;
  logic [23:0] period;
  logic [23:0] refresh;

  // latched item
  logic        op_q;
  logic [5:0]  idx_q;
  logic [23:0] color_q;

  // bank bookkeeping: cur holds the bank with the latest pixel, fsel the frame bank
  logic [PIXELS-1:0] cur;
  logic [PIXELS-1:0] cur_next;
  logic [PIXELS-1:0] fsel;
  logic [PIXELS-1:0] v0;
  logic [PIXELS-1:0] v1;

  // sequencer
  logic [23:0]     tick;
  logic [BP_W-1:0] bp;
  logic [PIX_W-1:0] pix;
  logic [4:0]      bpos;
  logic            gap;
  logic            done_q;
  logic            sel_q;
  logic            vld_q;

  logic [PIX_W+5:0] idx_wide;
  logic [PIX_W-1:0] waddr;
  logic             in_range;
  logic             wr_en;
  logic             wbank;
  logic [23:0]      tick_inc;
  logic             gap_end;
  logic             per_end;
  logic             last_bit;
  logic             last_pos;
  logic [23:0]      rdata0;
  logic [23:0]      rdata1;
  logic [23:0]      word;
  logic             bit_val;
  logic [23:0]      high_time;
  logic             line_next;
  logic [BP_W+10:0] bp_wide;

  assign cfg_ready = 1'b1;

  assign idx_wide = (PIX_W + 6)'(idx_q);
  assign waddr    = idx_wide[PIX_W-1:0];
  assign in_range = idx_wide < (PIX_W + 6)'(PIXELS);
  assign wr_en    = cmd.update && (op_q == OP_WRITE) && in_range;
  assign wbank    = ~fsel[waddr];

  always_comb begin
    cur_next = cur;
    if (wr_en) begin
      cur_next[waddr] = wbank;
    end
  end

  assign tick_inc = tick + 24'd1;
  assign gap_end  = (tick_inc >= refresh) || (tick_inc == 24'd0);
  assign per_end  = (tick_inc >= period) || (tick_inc == 24'd0);
  assign last_bit = (bp == BP_W'(FRAME_BITS - 1));
  assign last_pos = (bpos == 5'd23);

  alpe_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_bank0 (
    .clk  (clk),
    .we   (wr_en && !wbank),
    .waddr(waddr),
    .wdata(color_q),
    .re   (cmd.read),
    .raddr(pix),
    .rdata(rdata0)
  );

  alpe_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_bank1 (
    .clk  (clk),
    .we   (wr_en && wbank),
    .waddr(waddr),
    .wdata(color_q),
    .re   (cmd.read),
    .raddr(pix),
    .rdata(rdata1)
  );

  assign word      = sel_q ? rdata1 : rdata0;
  assign bit_val   = vld_q && word[5'd23 - bpos];
  assign high_time = bit_val ? high_one : high_zero;
  assign line_next = enable && !gap && (tick < high_time);
  assign bp_wide   = (BP_W + 11)'(bp);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      high_one  <= HIGH_ONE_RESET;
      high_zero <= HIGH_ZERO_RESET;
      period    <= PERIOD_RESET;
      refresh   <= REFRESH_RESET;
      cur       <= '0;
      fsel      <= '0;
      v0        <= '0;
      v1        <= '0;
      tick      <= '0;
      bp        <= '0;
      pix       <= '0;
      bpos      <= '0;
      gap       <= 1'b1;
      done_q    <= 1'b0;
      sel_q     <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ENABLE:    enable    <= |(cfg_data & ENABLE_MASK);
          CFG_HIGH_ONE:  high_one  <= cfg_data;
          CFG_HIGH_ZERO: high_zero <= cfg_data;
          CFG_PERIOD:    period    <= cfg_data;
          CFG_REFRESH:   refresh   <= cfg_data;
          default: begin
          end
        endcase
      end

      if (cmd.update) begin
        done_q <= 1'b0;
        cur    <= cur_next;
        if (wr_en) begin
          if (wbank) begin
            v1[waddr] <= 1'b1;
          end else begin
            v0[waddr] <= 1'b1;
          end
        end
        if (!enable) begin
          gap  <= 1'b1;
          tick <= '0;
          bp   <= '0;
          pix  <= '0;
          bpos <= '0;
        end else if (op_q == OP_TICK) begin
          if (gap) begin
            if (gap_end) begin
              // snapshot of the pixel store becomes the frame
              fsel <= cur_next;
              gap  <= 1'b0;
              tick <= '0;
              bp   <= '0;
              pix  <= '0;
              bpos <= '0;
            end else begin
              tick <= tick_inc;
            end
          end else if (per_end) begin
            tick <= '0;
            if (last_bit) begin
              done_q <= 1'b1;
              gap    <= 1'b1;
              bp     <= '0;
              pix    <= '0;
              bpos   <= '0;
            end else begin
              bp <= bp + BP_W'(1);
              if (last_pos) begin
                bpos <= '0;
                pix  <= pix + PIX_W'(1);
              end else begin
                bpos <= bpos + 5'd1;
              end
            end
          end else begin
            tick <= tick_inc;
          end
        end
      end

      if (cmd.read) begin
        sel_q <= fsel[pix];
        vld_q <= fsel[pix] ? v1[pix] : v0[pix];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q    <= operation;
      idx_q   <= pixel_index;
      color_q <= {green, red, blue};
    end
    if (cmd.load_out) begin
      line_level <= line_next;
      bit_number <= gap ? 11'd0 : bp_wide[10:0];
      in_gap     <= gap;
      frame_done <= done_q;
    end
  end

endmodule

>>> hw/rtl/alpe_checker.sv
// alpe_checker: port level assertions for the LED pulse encoder, bound to the top level.
// Depends on alpe_pkg.
module alpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        line_level,
  input logic [10:0] bit_number,
  input logic        in_gap,
  input logic        frame_done,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  import alpe_pkg::*;

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken while previous one in work");

  // the last bit period ending always enters the gap
  a_done_in_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> in_gap)
    else $error("frame_done outside the refresh gap");

  // in the gap the line is low and no bit is reported
  a_gap_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_gap) |-> (!line_level && bit_number == 11'd0))
    else $error("line active or bit number set during gap");

  // a stalled transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(line_level) &&
      $stable(bit_number) && $stable(in_gap) && $stable(frame_done)))
    else $error("stalled result changed");

  // register writes are never held off
  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write not taken");

endmodule

bind addressable_led_pulse_encoder alpe_checker u_alpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .line_level(line_level),
  .bit_number(bit_number),
  .in_gap    (in_gap),
  .frame_done(frame_done),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
